/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define UOT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define UOT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/uot_pkg.sv */
package uot_pkg;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_SUM    = 2'd3
  } uot_func_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } uot_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_SCAN  = 2'd2
  } uot_state_t;

  // input item
  typedef struct packed {
    uot_func_t   func;
    logic [63:0] block_index;
    logic [31:0] output_index;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [63:0] value_in;
  } uot_cmd_t;

  // result item
  typedef struct packed {
    uot_status_t status;
    logic [63:0] value_out;
    logic [63:0] found_key0;
    logic [63:0] found_key1;
    logic [63:0] found_key2;
    logic [63:0] found_key3;
    logic [7:0]  slot;
  } uot_result_t;

  // one table slot
  typedef struct packed {
    logic [63:0]  amount;
    logic [63:0]  block;
    logic [31:0]  outi;
    logic [255:0] key;
  } uot_entry_t;

  // store write controls
  typedef struct packed {
    logic amt_en;
    logic ent_en;
  } uot_wr_ctl_t;

endpackage

/* hw/rtl/uot_store.sv */
module uot_store import uot_pkg::*; #(
  parameter int ENTRIES = 256,
  parameter int IDX_W   = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output uot_entry_t       rd_data,
  input  uot_wr_ctl_t      wr_ctl,
  input  logic [IDX_W-1:0] wr_addr,
  input  uot_entry_t       wr_data
);

  logic [63:0]  amount_mem [ENTRIES];
  logic [63:0]  block_mem  [ENTRIES];
  logic [31:0]  output_mem [ENTRIES];
  logic [255:0] key_mem    [ENTRIES];

  // write port: amount alone, or the whole slot
  always_ff @(posedge clk) begin
    if (wr_ctl.amt_en || wr_ctl.ent_en) begin
      amount_mem[wr_addr] <= wr_data.amount;
    end
    if (wr_ctl.ent_en) begin
      block_mem[wr_addr]  <= wr_data.block;
      output_mem[wr_addr] <= wr_data.outi;
      key_mem[wr_addr]    <= wr_data.key;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.amount <= amount_mem[rd_addr];
      rd_data.block  <= block_mem[rd_addr];
      rd_data.outi   <= output_mem[rd_addr];
      rd_data.key    <= key_mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/unspent_output_table.sv */
// Table of unspent outputs, one slot per entry, scanned in slot order by a
// single read port with one compare and add unit behind it. After reset the
// block clears every amount, one slot per cycle, and holds busy high until
// the clearing pass is over. The scan reads one slot per cycle and the read
// is registered. Insert, remove and lookup stop at the first hit; sum always
// walks the whole table; an insert of a zero amount answers on the next
// cycle. done is high for exactly one cycle with the result, which must be
// taken then; busy is already low in that cycle, so the next start may
// coincide with it.
module unspent_output_table import uot_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  uot_cmd_t    cmd,
  output logic        done,
  output uot_result_t result
);

  `include "assert_macros.svh"

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);

  uot_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             d_valid, d_valid_next;
  logic             d_last, d_last_next;
  logic [IDX_W-1:0] d_idx, d_idx_next;
  uot_cmd_t         op, op_next;
  logic [63:0]      total, total_next;
  logic             over, over_next;
  logic             done_next;
  uot_result_t      result_next;

  logic             rd_en;
  uot_entry_t       rd_data;
  uot_wr_ctl_t      wr_ctl;
  logic [IDX_W-1:0] wr_addr;
  uot_entry_t       wr_data;

  logic             issue, live, idx_hit, key_hit, hit, finish, sat;
  logic [64:0]      add_sum;
  logic [63:0]      sum_val;

  uot_store #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (cnt[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_ctl  (wr_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // slot compare and running sum on the slot read last cycle
  always_comb begin
    issue   = (state == ST_SCAN) && (cnt < CNT_END);
    live    = (rd_data.amount != 64'd0);
    idx_hit = (rd_data.block == op.block_index) && (rd_data.outi == op.output_index);
    key_hit = (rd_data.key == {op.key_word3, op.key_word2, op.key_word1, op.key_word0});
    case (op.func)
      FUNC_INSERT: hit = !live;
      FUNC_REMOVE: hit = live && idx_hit;
      FUNC_LOOKUP: hit = live && idx_hit;
      default:     hit = 1'b0;
    endcase
    add_sum = {1'b0, total} + {1'b0, (key_hit ? rd_data.amount : 64'd0)};
    sat     = add_sum[64];
    sum_val = sat ? '1 : add_sum[63:0];
    finish  = (state == ST_SCAN) && d_valid && (hit || d_last);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (cnt == CNT_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start && !(cmd.func == FUNC_INSERT && cmd.value_in == 64'd0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath, store controls and result
  always_comb begin
    cnt_next     = cnt;
    op_next      = op;
    total_next   = total;
    over_next    = over;
    d_valid_next = 1'b0;
    d_last_next  = (cnt == CNT_LAST);
    d_idx_next   = cnt[IDX_W-1:0];
    done_next    = 1'b0;
    result_next  = '0;
    rd_en        = issue;
    wr_ctl       = '0;
    wr_addr      = d_idx;
    wr_data.amount = 64'd0;
    wr_data.block  = op.block_index;
    wr_data.outi   = op.output_index;
    wr_data.key    = {op.key_word3, op.key_word2, op.key_word1, op.key_word0};
    case (state)
      ST_CLEAR: begin
        wr_ctl.amt_en = 1'b1;
        wr_addr       = cnt[IDX_W-1:0];
        cnt_next      = cnt + CNT_W'(1);
      end
      ST_IDLE: begin
        if (start) begin
          op_next    = cmd;
          cnt_next   = '0;
          total_next = 64'd0;
          over_next  = 1'b0;
          // zero amount insert answers at once
          if (cmd.func == FUNC_INSERT && cmd.value_in == 64'd0) begin
            done_next = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (issue) cnt_next = cnt + CNT_W'(1);
        d_valid_next = issue && !finish;
        if (d_valid) begin
          // writes on a hit
          if (hit && op.func == FUNC_INSERT) begin
            wr_ctl.ent_en  = 1'b1;
            wr_data.amount = op.value_in;
          end
          if (hit && op.func == FUNC_REMOVE) wr_ctl.amt_en = 1'b1;
          if (op.func == FUNC_SUM) begin
            total_next = sum_val;
            over_next  = over || sat;
          end
        end
        if (finish) begin
          done_next = 1'b1;
          case (op.func)
            FUNC_INSERT: begin
              if (hit) result_next.slot = 8'(d_idx);
              else result_next.status = STAT_FULL;
            end
            FUNC_REMOVE: begin
              if (hit) result_next.slot = 8'(d_idx);
              else result_next.status = STAT_NOT_FOUND;
            end
            FUNC_LOOKUP: begin
              if (hit) begin
                result_next.slot       = 8'(d_idx);
                result_next.value_out  = rd_data.amount;
                result_next.found_key0 = rd_data.key[63:0];
                result_next.found_key1 = rd_data.key[127:64];
                result_next.found_key2 = rd_data.key[191:128];
                result_next.found_key3 = rd_data.key[255:192];
              end else begin
                result_next.status = STAT_NOT_FOUND;
              end
            end
            default: begin
              result_next.value_out = sum_val;
              result_next.status    = (over || sat) ? STAT_OVERFLOW : STAT_OK;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= '0;
      d_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      d_valid <= d_valid_next;
      done    <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    d_last <= d_last_next;
    d_idx  <= d_idx_next;
    op     <= op_next;
    total  <= total_next;
    over   <= over_next;
    result <= result_next;
  end

  assign busy = (state != ST_IDLE);

  `UOT_ASSERT(a_no_done_in_clear, clk, rst, done |-> $past(state) != ST_CLEAR,
    "result during clearing pass")
  `UOT_ASSERT(a_ovf_saturates, clk, rst,
    done && result.status == STAT_OVERFLOW |-> result.value_out == '1,
    "overflow without saturated total")
  `UOT_ASSERT(a_miss_zero, clk, rst,
    done && result.status == STAT_NOT_FOUND |-> result.slot == 8'd0 && result.value_out == 64'd0,
    "miss result not zeroed")
  `UOT_ASSERT(a_one_write, clk, rst, !(wr_ctl.amt_en && wr_ctl.ent_en),
    "two write kinds at once")
  `UOT_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> state == ST_CLEAR && !done,
    "reset did not start the clearing pass")

endmodule

/* verif/unspent_output_table_tb.sv */
`timescale 1ns / 1ps

module unspent_output_table_tb import uot_pkg::*;;

  localparam int SLOTS = 256;
  localparam int SEGMENTS = 10;
  localparam int ITEMS_PER_SEGMENT = 190;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [31:0] ALL_ONES32 = '1;
  localparam logic [255:0] KEY_ONES = '1;
  localparam logic [255:0] KEY_PAT = {4{64'h5555_AAAA_3333_CCCC}};
  localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;

  // operation mixes for the random segments
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BLEND} op_mix_t;

  typedef struct packed {
    uot_cmd_t    c;
    bit          typed;
    uot_result_t r;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  uot_cmd_t    cmd = '0;
  logic        done;
  uot_result_t result;

  // shadow copy of the table
  logic [63:0]  ledger_amount [SLOTS];
  logic [63:0]  ledger_block [SLOTS];
  logic [31:0]  ledger_outi [SLOTS];
  logic [255:0] ledger_key [SLOTS];

  uot_result_t pending_results [$];
  int mismatch_count = 0;
  int idle_pct = 0;

  op_mix_t mix_plan [SEGMENTS] = '{MIX_FILL, MIX_FILL, MIX_BLEND, MIX_DRAIN, MIX_FILL,
                                   MIX_FILL, MIX_FILL, MIX_BLEND, MIX_DRAIN, MIX_DRAIN};
  int idle_plan [3] = '{0, 70, 13};
  logic [63:0] blk_pool [4] = '{64'd0, ALL_ONES, 64'd1, TOP_BIT};
  logic [31:0] outi_pool [4] = '{32'd0, ALL_ONES32, 32'd1, 32'd2};
  logic [255:0] key_pool [4];

  unspent_output_table #(.TABLE_ENTRIES(SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic uot_cmd_t ledger_cmd(uot_func_t f, logic [63:0] blk, logic [31:0] outi,
                                          logic [255:0] k, logic [63:0] val);
    uot_cmd_t c;
    c.func = f;
    c.block_index = blk;
    c.output_index = outi;
    {c.key_word3, c.key_word2, c.key_word1, c.key_word0} = k;
    c.value_in = val;
    return c;
  endfunction

  function automatic uot_result_t ledger_res(uot_status_t st, logic [63:0] val,
                                             logic [255:0] k, logic [7:0] slot);
    uot_result_t r;
    r.status = st;
    r.value_out = val;
    {r.found_key3, r.found_key2, r.found_key1, r.found_key0} = k;
    r.slot = slot;
    return r;
  endfunction

  // apply one item to the shadow table and return its result
  function automatic uot_result_t apply_ledger_op(uot_cmd_t c);
    uot_result_t r;
    logic [255:0] k;
    logic [63:0] total;
    bit hit;
    r = '0;
    k = {c.key_word3, c.key_word2, c.key_word1, c.key_word0};
    hit = 1'b0;
    total = '0;
    case (c.func)
      FUNC_INSERT: begin
        // zero amount writes nothing
        if (c.value_in != '0) begin
          for (int s = 0; s < SLOTS && !hit; s++) begin
            if (ledger_amount[s] == '0) begin
              hit = 1'b1;
              ledger_amount[s] = c.value_in;
              ledger_block[s] = c.block_index;
              ledger_outi[s] = c.output_index;
              ledger_key[s] = k;
              r.slot = 8'(s);
            end
          end
          if (!hit) r.status = STAT_FULL;
        end
      end
      FUNC_REMOVE: begin
        for (int s = 0; s < SLOTS && !hit; s++) begin
          if (ledger_amount[s] != '0 && ledger_block[s] == c.block_index &&
              ledger_outi[s] == c.output_index) begin
            hit = 1'b1;
            ledger_amount[s] = '0;
            ledger_block[s] = '0;
            ledger_outi[s] = '0;
            ledger_key[s] = '0;
            r.slot = 8'(s);
          end
        end
        if (!hit) r.status = STAT_NOT_FOUND;
      end
      FUNC_LOOKUP: begin
        for (int s = 0; s < SLOTS && !hit; s++) begin
          if (ledger_amount[s] != '0 && ledger_block[s] == c.block_index &&
              ledger_outi[s] == c.output_index) begin
            hit = 1'b1;
            r = ledger_res(STAT_OK, ledger_amount[s], ledger_key[s], 8'(s));
          end
        end
        if (!hit) r.status = STAT_NOT_FOUND;
      end
      default: begin
        // sum saturates and flags overflow
        for (int s = 0; s < SLOTS; s++) begin
          if (ledger_key[s] == k) begin
            if (total > ALL_ONES - ledger_amount[s]) begin
              total = ALL_ONES;
              r.status = STAT_OVERFLOW;
            end else begin
              total = total + ledger_amount[s];
            end
          end
        end
        r.value_out = total;
      end
    endcase
    return r;
  endfunction

  // present one item, wait for acceptance, queue its expected result
  task automatic send_item(uot_cmd_t c, bit typed, uot_result_t typed_res);
    int gap;
    uot_result_t want;
    gap = 0;
    if ($urandom_range(99) < idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(270, 1) : $urandom_range(3, 1);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    want = apply_ledger_op(c);
    if (typed) want = typed_res;
    pending_results.push_back(want);
  endtask

  task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    uot_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item value_out", '0, result.value_out);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(result.status));
        if (result.value_out !== want.value_out)
          flag_mismatch("value_out", want.value_out, result.value_out);
        if (result.found_key0 !== want.found_key0)
          flag_mismatch("found_key0", want.found_key0, result.found_key0);
        if (result.found_key1 !== want.found_key1)
          flag_mismatch("found_key1", want.found_key1, result.found_key1);
        if (result.found_key2 !== want.found_key2)
          flag_mismatch("found_key2", want.found_key2, result.found_key2);
        if (result.found_key3 !== want.found_key3)
          flag_mismatch("found_key3", want.found_key3, result.found_key3);
        if (result.slot !== want.slot)
          flag_mismatch("slot", 64'(want.slot), 64'(result.slot));
      end
    end
  end

  // stimulus
  initial begin
    directed_row_t rows [$];
    uot_cmd_t c;
    uot_func_t op;
    logic [63:0] v;
    logic [255:0] k;
    int roll, ins_lim, rem_lim, look_lim, pick, s;
    bit have_live;

    for (int i = 0; i < SLOTS; i++) begin
      ledger_amount[i] = '0;
      ledger_block[i] = '0;
      ledger_outi[i] = '0;
      ledger_key[i] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    key_pool[2] = {8{$urandom}};
    key_pool[3] = {8{$urandom}};

    // empty table, extremes, duplicates, overflow, removal
    rows.push_back('{ledger_cmd(FUNC_LOOKUP, '0, '0, '0, '0), 1'b1,
                     ledger_res(STAT_NOT_FOUND, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_REMOVE, ALL_ONES, ALL_ONES32, KEY_ONES, ALL_ONES), 1'b1,
                     ledger_res(STAT_NOT_FOUND, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_SUM, '0, '0, '0, '0), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_SUM, ALL_ONES, ALL_ONES32, KEY_ONES, ALL_ONES), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_INSERT, ALL_ONES, ALL_ONES32, KEY_ONES, '0), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_INSERT, ALL_ONES, ALL_ONES32, KEY_ONES, ALL_ONES), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_INSERT, '0, '0, '0, 64'd1), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd1)});
    rows.push_back('{ledger_cmd(FUNC_INSERT, ALL_ONES, ALL_ONES32, KEY_PAT, TOP_BIT), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd2)});
    rows.push_back('{ledger_cmd(FUNC_LOOKUP, ALL_ONES, ALL_ONES32, '0, '0), 1'b1,
                     ledger_res(STAT_OK, ALL_ONES, KEY_ONES, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_LOOKUP, ALL_ONES, 32'hFFFF_FFFE, '0, '0), 1'b1,
                     ledger_res(STAT_NOT_FOUND, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, ALL_ONES32, '0, '0), 1'b1,
                     ledger_res(STAT_NOT_FOUND, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_SUM, '0, '0, KEY_ONES, '0), 1'b1,
                     ledger_res(STAT_OK, ALL_ONES, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_INSERT, 64'd5, 32'd7, KEY_ONES, 64'd1), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd3)});
    rows.push_back('{ledger_cmd(FUNC_SUM, '0, '0, KEY_ONES, '0), 1'b1,
                     ledger_res(STAT_OVERFLOW, ALL_ONES, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_REMOVE, ALL_ONES, ALL_ONES32, '0, '0), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_LOOKUP, ALL_ONES, ALL_ONES32, '0, '0), 1'b1,
                     ledger_res(STAT_OK, TOP_BIT, KEY_PAT, 8'd2)});
    rows.push_back('{ledger_cmd(FUNC_INSERT, 64'd9, 32'd3, '0, 64'd3), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_SUM, '0, '0, '0, '0), 1'b0, '0});
    rows.push_back('{ledger_cmd(FUNC_SUM, '0, '0, KEY_PAT, '0), 1'b0, '0});
    rows.push_back('{ledger_cmd(FUNC_REMOVE, '0, '0, '0, '0), 1'b1,
                     ledger_res(STAT_OK, '0, '0, 8'd1)});
    rows.push_back('{ledger_cmd(FUNC_REMOVE, '0, '0, '0, '0), 1'b1,
                     ledger_res(STAT_NOT_FOUND, '0, '0, 8'd0)});
    rows.push_back('{ledger_cmd(FUNC_LOOKUP, 64'd5, 32'd7, '0, '0), 1'b0, '0});
    rows.push_back('{ledger_cmd(FUNC_INSERT, ALL_ONES, ALL_ONES32, KEY_PAT, TOP_BIT), 1'b0, '0});
    rows.push_back('{ledger_cmd(FUNC_SUM, '0, '0, KEY_PAT, '0), 1'b0, '0});
    rows.push_back('{ledger_cmd(FUNC_REMOVE, 64'd5, 32'd7, '0, '0), 1'b0, '0});

    // reset, then the clearing pass shows up as busy
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    idle_pct = 0;
    foreach (rows[i]) send_item(rows[i].c, rows[i].typed, rows[i].r);

    // random segments: fill, drain and blended mixes over pooled indices and keys
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = idle_plan[seg % 3];
      case (mix_plan[seg])
        MIX_FILL: begin
          ins_lim = 80; rem_lim = 85; look_lim = 95;
        end
        MIX_DRAIN: begin
          ins_lim = 15; rem_lim = 75; look_lim = 90;
        end
        default: begin
          ins_lim = 35; rem_lim = 65; look_lim = 85;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
        roll = $urandom_range(99);
        if (roll < ins_lim) op = FUNC_INSERT;
        else if (roll < rem_lim) op = FUNC_REMOVE;
        else if (roll < look_lim) op = FUNC_LOOKUP;
        else op = FUNC_SUM;

        // indices mostly from small pools so duplicates and hits occur
        c.func = op;
        c.block_index = {$urandom, $urandom};
        c.output_index = $urandom;
        if ($urandom_range(9) < 6) c.block_index = blk_pool[$urandom_range(3)];
        if ($urandom_range(9) < 6) c.output_index = outi_pool[$urandom_range(3)];
        k = {8{$urandom}};
        if ($urandom_range(9) < 8) k = key_pool[$urandom_range(3)];

        // amounts: zero, top bit set, all ones or small
        roll = $urandom_range(99);
        v = {$urandom, $urandom};
        if (roll < 8) v = '0;
        else if (roll < 38) v[63] = 1'b1;
        else if (roll < 40) v = ALL_ONES;
        else v = 64'($urandom_range(1000, 1));
        c.value_in = v;

        // aim remove and lookup at a live slot most of the time, sum at times
        have_live = 1'b0;
        s = 0;
        pick = $urandom_range(SLOTS - 1);
        for (int j = 0; j < SLOTS && !have_live; j++) begin
          s = (pick + j) % SLOTS;
          if (ledger_amount[s] != '0) have_live = 1'b1;
        end
        if (have_live && (op == FUNC_REMOVE || op == FUNC_LOOKUP) &&
            $urandom_range(9) < 7) begin
          c.block_index = ledger_block[s];
          c.output_index = ledger_outi[s];
        end
        if (have_live && op == FUNC_SUM && $urandom_range(3) == 0) k = ledger_key[s];
        {c.key_word3, c.key_word2, c.key_word1, c.key_word0} = k;

        send_item(c, 1'b0, '0);
      end
    end
    start <= 1'b0;

    // drain, then allow a full scan for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
